[design/lift_relevel_controller_top_assert.svh]
// assertion macros for the lift relevel controller
// used by lift_relevel_controller_top; expects clk and rst_n in scope
`ifndef LIFT_RELEVEL_CONTROLLER_TOP_ASSERT_SVH
`define LIFT_RELEVEL_CONTROLLER_TOP_ASSERT_SVH

// condition must never hold outside reset
`define LRC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lrc: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define LRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrc: implication failed");

// antecedent implies consequent in the next cycle
`define LRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrc: next-cycle implication failed");

`endif

[design/lrc_pkg.sv]
// shared types and constants for the lift relevel controller
// used by lrc_core and lift_relevel_controller_top; no dependencies
`default_nettype none

package lrc_pkg;

  localparam int unsigned TickW    = 20;
  localparam int unsigned DeadW    = TickW + 1;
  localparam int unsigned AttW     = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // reset values of the configuration registers
  localparam logic [TickW-1:0] DebounceRst = 20'd3000;
  localparam logic [TickW-1:0] TripRst     = 20'd30000;
  localparam logic [AttW-1:0]  MaxAttRst   = 4'd6;
  localparam logic [AttW-1:0]  AttSat      = 4'd15;

  // caller mode codes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_RELEVEL = 2'd1;
  localparam logic [1:0] MODE_NOCHECK = 2'd2;

  // drive status codes
  localparam logic [1:0] DRV_STOPPED = 2'd0;
  localparam logic [1:0] DRV_RUNNING = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SHORT   = 3'd1,
    EV_LONG    = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_DONE    = 3'd4
  } event_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_WITH_CALL = 3'd1,
    CFG_DEBOUNCE  = 3'd2,
    CFG_TRIP      = 3'd3,
    CFG_MAX_ATT   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              enable;
    logic              with_call;
    logic [TickW-1:0]  debounce;
    logic [TickW-1:0]  trip;
    logic [AttW-1:0]   max_att;
  } cfg_t;

  typedef struct packed {
    logic       moving_up;
    logic [1:0] drive_status;
    logic       call_pending;
    logic       start_permit;
    logic [1:0] mode_in;
    logic       zone_down_sensor;
    logic       zone_up_sensor;
  } item_t;

  typedef struct packed {
    logic [AttW-1:0] attempt_count;
    event_t          event_code;
    logic            emergency_cmd;
    logic            stop_cmd;
    logic            start_up;
    logic            start_cmd;
    logic [1:0]      mode_out;
  } result_t;

endpackage

`default_nettype wire

[design/lift_relevel_controller_top.sv]
// lift relevel controller: stream wrapper, config registers, result register
// depends on lrc_pkg, lrc_core and lift_relevel_controller_top_assert.svh
//
// usage:
//   in_*   one word per timer tick: sensors, mode, permit, call, drive, direction
//   out_*  one result word per input word, in order
//   cfg_*  write-only registers, written while no word is in flight
// result: a word accepted at a clock edge is registered into the result
//   register and shown on out_* from the cycle after its acceptance.
// throughput: one word per cycle while the receiver takes results; limited only by the single result register.
// stalls: in_tready follows out_tready while a result is held, so a stalled
//   receiver holds the result stable and input back-pressure is immediate.
// reset (rst_n low, synchronous): deadline expired, attempts zero,
//   relevel disabled, debounce 3000, trip limit 30000, max attempts 6,
//   result register empty.
`default_nettype none

module lift_relevel_controller_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input words
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [0] zone_up_sensor [1] zone_down_sensor [3:2] mode_in [4] start_permit
  // [5] call_pending [7:6] drive_status [8] moving_up, rest zero
  input  wire logic [lrc_pkg::InDataW-1:0]   in_tdata,
  // result words
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [1:0] mode_out [2] start_cmd [3] start_up [4] stop_cmd [5] emergency_cmd
  // [8:6] event_code [12:9] attempt_count, rest zero
  output logic [lrc_pkg::OutDataW-1:0]       out_tdata,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [lrc_pkg::CfgIdxW-1:0]   cfg_addr,
  input  wire logic [lrc_pkg::TickW-1:0]     cfg_wdata
);

  localparam int unsigned ItemW = $bits(lrc_pkg::item_t);
  localparam int unsigned ResW  = $bits(lrc_pkg::result_t);

  lrc_pkg::cfg_t    cfg_r;
  lrc_pkg::item_t   item;
  lrc_pkg::result_t res, res_r;
  logic             out_valid_r;
  logic             in_acc;
  logic [1:0]       cmd_cnt;
  logic             out_emerg;
  logic             start_ok;
  logic             park_acc;
  logic             park_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b0;
      cfg_r.with_call <= 1'b0;
      cfg_r.debounce  <= lrc_pkg::DebounceRst;
      cfg_r.trip      <= lrc_pkg::TripRst;
      cfg_r.max_att   <= lrc_pkg::MaxAttRst;
    end else if (cfg_we) begin
      case (lrc_pkg::cfg_idx_t'(cfg_addr))
        lrc_pkg::CFG_ENABLE:    cfg_r.enable    <= cfg_wdata[0];
        lrc_pkg::CFG_WITH_CALL: cfg_r.with_call <= cfg_wdata[0];
        lrc_pkg::CFG_DEBOUNCE:  cfg_r.debounce  <= cfg_wdata;
        lrc_pkg::CFG_TRIP:      cfg_r.trip      <= cfg_wdata;
        lrc_pkg::CFG_MAX_ATT:   cfg_r.max_att   <= cfg_wdata[lrc_pkg::AttW-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: take a word whenever the result slot is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign item      = lrc_pkg::item_t'(in_tdata[ItemW-1:0]);

  lrc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_acc),
    .cfg   (cfg_r),
    .item  (item),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lrc_pkg::OutDataW - ResW){1'b0}}, res_r};

  // terms used by the checks below
  assign cmd_cnt   = 2'(res_r.start_cmd) + 2'(res_r.stop_cmd) + 2'(res_r.emergency_cmd);
  assign out_emerg = out_valid_r && res_r.emergency_cmd;
  assign start_ok  = (res_r.mode_out == lrc_pkg::MODE_RELEVEL) && (res_r.attempt_count != '0);
  assign park_acc  = in_acc && (item.mode_in == lrc_pkg::MODE_IDLE) &&
                     item.zone_up_sensor && item.zone_down_sensor;
  assign park_ok   = (res_r.attempt_count == '0) && !res_r.start_cmd;

`include "lift_relevel_controller_top_assert.svh"

  `LRC_ASSERT_NEVER(a_cmd_exclusive, out_valid_r && (cmd_cnt > 2'd1))
  `LRC_ASSERT_IMPL(a_emerg_event, out_emerg, res_r.event_code == lrc_pkg::EV_TIMEOUT)
  `LRC_ASSERT_IMPL(a_start_mode, out_valid_r && res_r.start_cmd, start_ok)
  `LRC_ASSERT_NEXT(a_in_zone_clear, park_acc, out_valid_r && park_ok)

endmodule

`default_nettype wire

[design/lrc_core.sv]
// relevel decision logic and controller state (deadline, attempts, direction)
// depends on lrc_pkg; one word processed per step strobe
`default_nettype none

module lrc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire lrc_pkg::cfg_t   cfg,
  input  wire lrc_pkg::item_t  item,
  output lrc_pkg::result_t     res
);

  logic [lrc_pkg::DeadW-1:0] deadline_r, deadline_nxt, deadline_dec;
  logic [lrc_pkg::AttW-1:0]  attempts_r, attempts_nxt;
  logic                      chosen_up_r, chosen_up_nxt;
  logic                      reached_r, reached_nxt;
  logic                      both, expired, may_start;

  // deadline ticks down first, saturating at zero
  always_comb begin
    deadline_dec = (deadline_r != '0) ? deadline_r - 1'b1 : '0;
    expired      = (deadline_dec == '0);
    both         = item.zone_up_sensor & item.zone_down_sensor;
    may_start    = expired && cfg.enable && (attempts_r < cfg.max_att) &&
                   item.start_permit &&
                   (item.zone_up_sensor | item.zone_down_sensor) &&
                   (!item.call_pending || cfg.with_call);
  end

  // next state and result for this tick
  always_comb begin
    deadline_nxt      = deadline_dec;
    attempts_nxt      = attempts_r;
    chosen_up_nxt     = chosen_up_r;
    reached_nxt       = reached_r;
    res.mode_out      = item.mode_in;
    res.start_cmd     = 1'b0;
    res.start_up      = 1'b0;
    res.stop_cmd      = 1'b0;
    res.emergency_cmd = 1'b0;
    res.event_code    = lrc_pkg::EV_NONE;

    if (item.mode_in == lrc_pkg::MODE_IDLE) begin
      res.mode_out = lrc_pkg::MODE_IDLE;
      if (both) begin
        // parked in zone: restart debounce, forget failures
        deadline_nxt = {1'b0, cfg.debounce} + 1'b1;
        attempts_nxt = '0;
      end else if (may_start) begin
        chosen_up_nxt = item.zone_up_sensor;
        res.start_cmd = 1'b1;
        res.start_up  = item.zone_up_sensor;
        if (attempts_r < lrc_pkg::AttSat) begin
          attempts_nxt = attempts_r + 1'b1;
        end
        reached_nxt  = 1'b0;
        deadline_nxt = {1'b0, cfg.trip} + 1'b1;
        res.mode_out = lrc_pkg::MODE_RELEVEL;
      end
    end else if (item.drive_status == lrc_pkg::DRV_STOPPED) begin
      // classify where the car came to rest
      res.event_code = lrc_pkg::EV_DONE;
      if (!both && item.mode_in != lrc_pkg::MODE_NOCHECK) begin
        if ((chosen_up_r && !item.zone_down_sensor) ||
            (!chosen_up_r && !item.zone_up_sensor)) begin
          res.event_code = lrc_pkg::EV_SHORT;
        end else begin
          res.event_code = lrc_pkg::EV_LONG;
        end
      end
      deadline_nxt = {1'b0, cfg.debounce} + 1'b1;
      res.mode_out = lrc_pkg::MODE_IDLE;
    end else if (item.drive_status == lrc_pkg::DRV_RUNNING) begin
      if (expired) begin
        res.emergency_cmd = 1'b1;
        res.event_code    = lrc_pkg::EV_TIMEOUT;
      end else if (!reached_r) begin
        // far-side sensor coming on means the car reached level
        if ((item.moving_up && item.zone_down_sensor) ||
            (!item.moving_up && item.zone_up_sensor)) begin
          reached_nxt  = 1'b1;
          res.stop_cmd = 1'b1;
        end
      end
    end
    res.attempt_count = attempts_nxt;
  end

  // state registers advance once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r  <= '0;
      attempts_r  <= '0;
      chosen_up_r <= 1'b0;
      reached_r   <= 1'b0;
    end else if (step) begin
      deadline_r  <= deadline_nxt;
      attempts_r  <= attempts_nxt;
      chosen_up_r <= chosen_up_nxt;
      reached_r   <= reached_nxt;
    end
  end

endmodule

`default_nettype wire
